// ===== rtl/obstacle_avoid_drive_sequencer_assert.svh =====
// Assertion macros for the top-level RTL; clock clk, reset rst_n active low.
`ifndef OBSTACLE_AVOID_DRIVE_SEQUENCER_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define OADS_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("implication check failed");

// Next-cycle implication.
`define OADS_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/oads_pkg.sv =====
package oads_pkg;

    localparam int COUNT_BITS = 8;
    localparam int TIMER_BITS = 16;

    // Compare widths cover both the counter and its 8/16 bit limit register
    localparam int CNT_CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam int TMR_CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Drive modes
    localparam logic [2:0] M_STOP    = 3'd0;
    localparam logic [2:0] M_CRUISE  = 3'd1;
    localparam logic [2:0] M_REVERSE = 3'd2;
    localparam logic [2:0] M_ROTATE  = 3'd3;
    localparam logic [2:0] M_RIGHT   = 3'd4;
    localparam logic [2:0] M_LEFT    = 3'd5;

    // Motor directions
    localparam logic [1:0] D_STOP = 2'd0;
    localparam logic [1:0] D_FWD  = 2'd1;
    localparam logic [1:0] D_REV  = 2'd2;

    // Last turn codes
    localparam logic [1:0] LT_NONE  = 2'd0;
    localparam logic [1:0] LT_LEFT  = 2'd1;
    localparam logic [1:0] LT_RIGHT = 2'd2;

    // Register indexes
    localparam logic [2:0] R_IR_DETECT     = 3'd0;
    localparam logic [2:0] R_NEAR_DISTANCE = 3'd1;
    localparam logic [2:0] R_BACK_TIME     = 3'd2;
    localparam logic [2:0] R_ROTATE_TICKS  = 3'd3;
    localparam logic [2:0] R_TURN_TICKS    = 3'd4;
    localparam logic [2:0] R_TURN_SPEED    = 3'd5;
    localparam logic [2:0] R_CRUISE_SPEED  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [9:0]  ir_detect_level;
        logic [7:0]  near_distance_cm;
        logic [15:0] back_time_ms;
        logic [7:0]  rotate_ticks;
        logic [7:0]  turn_ticks;
        logic [7:0]  turn_speed;
        logic [7:0]  cruise_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ir_detect_level:  10'd500,
        near_distance_cm: 8'd15,
        back_time_ms:     16'd300,
        rotate_ticks:     8'd60,
        turn_ticks:       8'd30,
        turn_speed:       8'd150,
        cruise_speed:     8'd170
    };

    typedef struct packed {
        logic [9:0]  ir_left_level;
        logic [9:0]  ir_right_level;
        logic [15:0] echo_width_us;
        logic        sample_valid;
        logic        left_edge;
        logic        right_edge;
        logic        ms_strobe;
    } in_item_t;

    typedef struct packed {
        logic [1:0] motor_a_dir;
        logic [1:0] motor_b_dir;
        logic [7:0] motor_a_duty;
        logic [7:0] motor_b_duty;
        logic [2:0] drive_mode;
        logic       obstacle_near;
    } result_t;

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
        cnt_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [TIMER_BITS-1:0] tmr_inc(input logic [TIMER_BITS-1:0] v);
        tmr_inc = (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/oads_cfg.sv =====
module oads_cfg
    import oads_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                R_IR_DETECT:     cfg_next.ir_detect_level  = cfg_wdata[9:0];
                R_NEAR_DISTANCE: cfg_next.near_distance_cm = cfg_wdata[7:0];
                R_BACK_TIME:     cfg_next.back_time_ms     = cfg_wdata[15:0];
                R_ROTATE_TICKS:  cfg_next.rotate_ticks     = cfg_wdata[7:0];
                R_TURN_TICKS:    cfg_next.turn_ticks       = cfg_wdata[7:0];
                R_TURN_SPEED:    cfg_next.turn_speed       = cfg_wdata[7:0];
                R_CRUISE_SPEED:  cfg_next.cruise_speed     = cfg_wdata[7:0];
                default:         cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/oads_core.sv =====
module oads_core
    import oads_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     item_vld,
    input  in_item_t item,
    input  logic     res_stall,
    output logic     advance,
    output logic     res_vld,
    output result_t  res
);

    logic [2:0]            mode_reg,  mode_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [COUNT_BITS-1:0] lt_reg,    lt_next;
    logic [COUNT_BITS-1:0] rt_reg,    rt_next;
    logic [1:0]            last_reg,  last_next;
    logic                  near_reg,  near_next;
    logic                  res_vld_reg, res_vld_next;
    result_t               res_reg,   res_next;
    logic                  proc;

    logic [20:0]           echo_x17;
    logic [20:0]           near_lim;
    logic                  near;
    logic                  hit_l, hit_r;
    logic [COUNT_BITS-1:0] lt_i, rt_i;
    logic [TIMER_BITS-1:0] tmr_i;
    logic [CNT_CMP_W-1:0]  lt_w, rt_w, rot_w, turn_w;
    logic [TMR_CMP_W-1:0]  tmr_w, back_w;

    assign advance = !res_vld_reg || !res_stall;
    assign proc    = item_vld && advance;

    // distance < near  <=>  echo * 17 < near_cm * 1000
    assign echo_x17 = {1'b0, item.echo_width_us, 4'b0} + 21'(item.echo_width_us);
    assign near_lim = 21'(cfg.near_distance_cm) * 21'd1000;
    assign near     = echo_x17 < near_lim;
    assign hit_l    = item.ir_left_level > cfg.ir_detect_level;
    assign hit_r    = item.ir_right_level > cfg.ir_detect_level;

    assign lt_i  = item.left_edge  ? cnt_inc(lt_reg) : lt_reg;
    assign rt_i  = item.right_edge ? cnt_inc(rt_reg) : rt_reg;
    assign tmr_i = item.ms_strobe  ? tmr_inc(timer_reg) : timer_reg;

    assign lt_w   = CNT_CMP_W'(lt_i);
    assign rt_w   = CNT_CMP_W'(rt_i);
    assign rot_w  = CNT_CMP_W'(cfg.rotate_ticks);
    assign turn_w = CNT_CMP_W'(cfg.turn_ticks);
    assign tmr_w  = TMR_CMP_W'(tmr_i);
    assign back_w = TMR_CMP_W'(cfg.back_time_ms);

    always_comb
    begin
        mode_next  = mode_reg;
        timer_next = timer_reg;
        lt_next    = lt_reg;
        rt_next    = rt_reg;
        last_next  = last_reg;
        near_next  = near_reg;

        if (item.sample_valid)
        begin
            near_next = near;
        end

        if (item.sample_valid && (mode_reg == M_STOP || mode_reg == M_CRUISE))
        begin
            // pick the next action; edges and strobe of this beat are not counted
            if (near || (hit_l && hit_r))
            begin
                mode_next  = M_REVERSE;
                timer_next = '0;
                lt_next    = '0;
                rt_next    = '0;
            end
            else if (hit_l)
            begin
                mode_next = M_RIGHT;
                lt_next   = '0;
                rt_next   = '0;
            end
            else if (hit_r)
            begin
                mode_next = M_LEFT;
                lt_next   = '0;
                rt_next   = '0;
            end
            else
            begin
                mode_next = M_CRUISE;
            end
        end
        else if (mode_reg != M_STOP && mode_reg != M_CRUISE)
        begin
            lt_next = lt_i;
            rt_next = rt_i;
            case (mode_reg)
                M_REVERSE:
                begin
                    timer_next = tmr_i;
                    if (tmr_w >= back_w || tmr_i == TIMER_MAX)
                    begin
                        mode_next = M_ROTATE;
                        lt_next   = '0;
                        rt_next   = '0;
                    end
                end
                M_ROTATE:
                begin
                    if (lt_w > rot_w || rt_w > rot_w ||
                        lt_i == COUNT_MAX || rt_i == COUNT_MAX)
                    begin
                        mode_next = M_STOP;
                        last_next = (last_reg == LT_LEFT) ? LT_RIGHT : LT_LEFT;
                    end
                end
                M_RIGHT:
                begin
                    if (lt_w >= turn_w || lt_i == COUNT_MAX)
                    begin
                        mode_next = M_STOP;
                        last_next = LT_RIGHT;
                    end
                end
                M_LEFT:
                begin
                    if (rt_w >= turn_w || rt_i == COUNT_MAX)
                    begin
                        mode_next = M_STOP;
                        last_next = LT_LEFT;
                    end
                end
                default:
                begin
                    mode_next = M_STOP;
                end
            endcase
        end
    end

    // Motor commands follow the state left by this beat
    always_comb
    begin
        res_next               = '0;
        res_next.drive_mode    = mode_next;
        res_next.obstacle_near = near_next;
        case (mode_next)
            M_CRUISE:
            begin
                res_next.motor_a_dir  = D_FWD;
                res_next.motor_b_dir  = D_FWD;
                res_next.motor_a_duty = cfg.cruise_speed;
                res_next.motor_b_duty = cfg.cruise_speed;
            end
            M_REVERSE:
            begin
                res_next.motor_a_dir  = D_REV;
                res_next.motor_b_dir  = D_REV;
                res_next.motor_a_duty = cfg.turn_speed;
                res_next.motor_b_duty = cfg.turn_speed;
            end
            M_ROTATE:
            begin
                res_next.motor_a_dir  = (last_next == LT_LEFT) ? D_FWD : D_REV;
                res_next.motor_b_dir  = (last_next == LT_LEFT) ? D_REV : D_FWD;
                res_next.motor_a_duty = cfg.turn_speed;
                res_next.motor_b_duty = cfg.turn_speed;
            end
            M_RIGHT:
            begin
                res_next.motor_a_dir  = D_FWD;
                res_next.motor_b_dir  = D_REV;
                res_next.motor_a_duty = cfg.turn_speed;
                res_next.motor_b_duty = cfg.turn_speed;
            end
            M_LEFT:
            begin
                res_next.motor_a_dir  = D_REV;
                res_next.motor_b_dir  = D_FWD;
                res_next.motor_a_duty = cfg.turn_speed;
                res_next.motor_b_duty = cfg.turn_speed;
            end
            default:
            begin
                res_next.motor_a_dir = D_STOP;
            end
        endcase
    end

    assign res_vld_next = proc ? 1'b1 : (res_vld_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_STOP;
            timer_reg   <= '0;
            lt_reg      <= '0;
            rt_reg      <= '0;
            last_reg    <= LT_NONE;
            near_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (proc)
            begin
                mode_reg  <= mode_next;
                timer_reg <= timer_next;
                lt_reg    <= lt_next;
                rt_reg    <= rt_next;
                last_reg  <= last_next;
                near_reg  <= near_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            res_reg <= res_next;
        end
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

// ===== rtl/obstacle_avoid_drive_sequencer.sv =====
// Pipeline: an accepted input beat reaches its result beat through the input and result registers.
// Throughput: one beat per cycle when not stalled; the state logic sits behind the input register.
// Backpressure: a stalled result holds the result register; the input register then holds too.
// Reset (rst_n low, asynchronous): both stages empty, drive stopped, counters and timer zero,
// no last turn, config registers back to their defaults.
module obstacle_avoid_drive_sequencer
    import oads_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [9:0]            ir_left_level,
    input  logic [9:0]            ir_right_level,
    input  logic [15:0]           echo_width_us,
    input  logic                  sample_valid,
    input  logic                  left_edge,
    input  logic                  right_edge,
    input  logic                  ms_strobe,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            motor_a_dir,
    output logic [1:0]            motor_b_dir,
    output logic [7:0]            motor_a_duty,
    output logic [7:0]            motor_b_duty,
    output logic [2:0]            drive_mode,
    output logic                  obstacle_near
);

`include "obstacle_avoid_drive_sequencer_assert.svh"

    cfg_t     cfg;
    in_item_t in_item_reg;
    logic     in_vld_reg, in_vld_next;
    logic     core_adv;
    logic     res_vld;
    result_t  res;

    oads_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Hold the input beat only while the core cannot take it
    assign in_stall    = in_vld_reg && !core_adv;
    assign in_vld_next = in_stall ? in_vld_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // Capture the payload on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg.ir_left_level  <= ir_left_level;
            in_item_reg.ir_right_level <= ir_right_level;
            in_item_reg.echo_width_us  <= echo_width_us;
            in_item_reg.sample_valid   <= sample_valid;
            in_item_reg.left_edge      <= left_edge;
            in_item_reg.right_edge     <= right_edge;
            in_item_reg.ms_strobe      <= ms_strobe;
        end
    end

    // Sequencer state and result register
    oads_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_vld  (in_vld_reg),
        .item      (in_item_reg),
        .res_stall (out_stall),
        .advance   (core_adv),
        .res_vld   (res_vld),
        .res       (res)
    );

    assign out_valid     = res_vld;
    assign motor_a_dir   = res.motor_a_dir;
    assign motor_b_dir   = res.motor_b_dir;
    assign motor_a_duty  = res.motor_a_duty;
    assign motor_b_duty  = res.motor_b_duty;
    assign drive_mode    = res.drive_mode;
    assign obstacle_near = res.obstacle_near;

    // The input stage only stalls while it holds a beat
    `OADS_ASSERT_IMP(a_stall_needs_item, in_stall, in_vld_reg)
    // A stopped result drives nothing
    `OADS_ASSERT_IMP(a_stop_is_idle, out_valid && drive_mode == M_STOP,
        motor_a_duty == 8'd0 && motor_b_duty == 8'd0 &&
        motor_a_dir == D_STOP && motor_b_dir == D_STOP)
    // Spinning in place always drives the wheels against each other
    `OADS_ASSERT_IMP(a_rotate_opposed, out_valid && drive_mode == M_ROTATE,
        motor_a_dir != motor_b_dir && motor_a_dir != D_STOP && motor_b_dir != D_STOP)
    // A stalled input beat is passed on once the result side drains
    `OADS_ASSERT_NEXT(a_stall_releases, in_stall && !out_stall, !in_stall || out_valid)

endmodule

// ===== test/obstacle_avoid_drive_sequencer_tb.sv =====
`timescale 1ns / 1ps

module obstacle_avoid_drive_sequencer_tb;
    import oads_pkg::*;

    // Index past the last register; writes to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] R_UNUSED = 3'd7;

    // Directed config picks.
    localparam int DCFG_NONE  = 0;
    localparam int DCFG_SHORT = 1;
    localparam int DCFG_ZERO  = 2;

    localparam int NUM_PHASES = 8;

    typedef struct {
        int       cfg_sel;
        in_item_t item;
        bit       fixed_on;
        result_t  fixed;
    } drive_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [9:0]            ir_left_level = '0;
    logic [9:0]            ir_right_level = '0;
    logic [15:0]           echo_width_us = '0;
    logic                  sample_valid = 1'b0;
    logic                  left_edge = 1'b0;
    logic                  right_edge = 1'b0;
    logic                  ms_strobe = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            motor_a_dir;
    logic [1:0]            motor_b_dir;
    logic [7:0]            motor_a_duty;
    logic [7:0]            motor_b_duty;
    logic [2:0]            drive_mode;
    logic                  obstacle_near;

    // Predicted copy of the sequencer: settings plus internal state.
    cfg_t                  pred_cfg = CFG_RESET;
    logic [2:0]            pred_mode = M_STOP;
    logic [TIMER_BITS-1:0] pred_back_timer = '0;
    logic [COUNT_BITS-1:0] pred_left_ticks = '0;
    logic [COUNT_BITS-1:0] pred_right_ticks = '0;
    logic [1:0]            pred_last_turn = LT_NONE;
    logic                  pred_near = 1'b0;

    result_t    expected_drive_q[$];
    result_t    exp_drive;
    drive_row_t directed_rows[$];

    int  error_count = 0;
    int  beats_sent = 0;
    int  results_checked = 0;
    int  settings_loaded = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    obstacle_avoid_drive_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ir_left_level  (ir_left_level),
        .ir_right_level (ir_right_level),
        .echo_width_us  (echo_width_us),
        .sample_valid   (sample_valid),
        .left_edge      (left_edge),
        .right_edge     (right_edge),
        .ms_strobe      (ms_strobe),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_a_dir    (motor_a_dir),
        .motor_b_dir    (motor_b_dir),
        .motor_a_duty   (motor_a_duty),
        .motor_b_duty   (motor_b_duty),
        .drive_mode     (drive_mode),
        .obstacle_near  (obstacle_near)
    );

    always #1 clk = ~clk;

    // Advance the predicted sequencer by one time slot and return its drive command.
    function automatic result_t predict_drive(input in_item_t it);
        result_t     r;
        bit          acted;
        bit          near_now;
        bit          hit_l;
        bit          hit_r;
        int unsigned echo_scaled;
        int unsigned near_scaled;
        r = '0;
        acted = 1'b0;
        if (it.sample_valid)
        begin
            echo_scaled = it.echo_width_us;
            echo_scaled = echo_scaled * 17;
            near_scaled = pred_cfg.near_distance_cm;
            near_scaled = near_scaled * 1000;
            near_now = echo_scaled < near_scaled;
            hit_l = it.ir_left_level > pred_cfg.ir_detect_level;
            hit_r = it.ir_right_level > pred_cfg.ir_detect_level;
            pred_near = near_now;
            // Only an idle or cruising robot picks a new action from the sample.
            if (pred_mode == M_STOP || pred_mode == M_CRUISE)
            begin
                acted = 1'b1;
                if (near_now || (hit_l && hit_r))
                begin
                    pred_mode = M_REVERSE;
                    pred_back_timer = '0;
                    pred_left_ticks = '0;
                    pred_right_ticks = '0;
                end
                else if (hit_l)
                begin
                    pred_mode = M_RIGHT;
                    pred_left_ticks = '0;
                    pred_right_ticks = '0;
                end
                else if (hit_r)
                begin
                    pred_mode = M_LEFT;
                    pred_left_ticks = '0;
                    pred_right_ticks = '0;
                end
                else
                begin
                    pred_mode = M_CRUISE;
                end
            end
        end
        // Busy modes: count edges and strobe first, then test the end of the phase.
        if (!acted && pred_mode >= M_REVERSE)
        begin
            if (it.left_edge && pred_left_ticks != COUNT_MAX)
                pred_left_ticks = pred_left_ticks + 1'b1;
            if (it.right_edge && pred_right_ticks != COUNT_MAX)
                pred_right_ticks = pred_right_ticks + 1'b1;
            case (pred_mode)
                M_REVERSE:
                begin
                    if (it.ms_strobe && pred_back_timer != TIMER_MAX)
                        pred_back_timer = pred_back_timer + 1'b1;
                    if (pred_back_timer >= pred_cfg.back_time_ms
                        || pred_back_timer == TIMER_MAX)
                    begin
                        pred_mode = M_ROTATE;
                        pred_left_ticks = '0;
                        pred_right_ticks = '0;
                    end
                end
                M_ROTATE:
                begin
                    if (pred_left_ticks > pred_cfg.rotate_ticks
                        || pred_right_ticks > pred_cfg.rotate_ticks
                        || pred_left_ticks == COUNT_MAX || pred_right_ticks == COUNT_MAX)
                    begin
                        pred_mode = M_STOP;
                        pred_last_turn = (pred_last_turn == LT_LEFT) ? LT_RIGHT : LT_LEFT;
                    end
                end
                M_RIGHT:
                begin
                    if (pred_left_ticks >= pred_cfg.turn_ticks || pred_left_ticks == COUNT_MAX)
                    begin
                        pred_mode = M_STOP;
                        pred_last_turn = LT_RIGHT;
                    end
                end
                default:
                begin
                    if (pred_right_ticks >= pred_cfg.turn_ticks
                        || pred_right_ticks == COUNT_MAX)
                    begin
                        pred_mode = M_STOP;
                        pred_last_turn = LT_LEFT;
                    end
                end
            endcase
        end
        case (pred_mode)
            M_CRUISE:
            begin
                r.motor_a_dir = D_FWD;
                r.motor_b_dir = D_FWD;
                r.motor_a_duty = pred_cfg.cruise_speed;
                r.motor_b_duty = pred_cfg.cruise_speed;
            end
            M_REVERSE:
            begin
                r.motor_a_dir = D_REV;
                r.motor_b_dir = D_REV;
            end
            M_ROTATE:
            begin
                // Spin away from the side of the last turn.
                r.motor_a_dir = (pred_last_turn == LT_LEFT) ? D_FWD : D_REV;
                r.motor_b_dir = (pred_last_turn == LT_LEFT) ? D_REV : D_FWD;
            end
            M_RIGHT:
            begin
                r.motor_a_dir = D_FWD;
                r.motor_b_dir = D_REV;
            end
            M_LEFT:
            begin
                r.motor_a_dir = D_REV;
                r.motor_b_dir = D_FWD;
            end
            default:
            begin
            end
        endcase
        if (pred_mode >= M_REVERSE)
        begin
            r.motor_a_duty = pred_cfg.turn_speed;
            r.motor_b_duty = pred_cfg.turn_speed;
        end
        r.drive_mode = pred_mode;
        r.obstacle_near = pred_near;
        return r;
    endfunction

    function automatic drive_row_t mk_row(input int sel, input int irl, input int irr,
                                          input int echo, input bit sv, input bit le,
                                          input bit re, input bit ms, input bit fx_on,
                                          input result_t fx);
        drive_row_t row;
        row.cfg_sel = sel;
        row.item.ir_left_level = 10'(irl);
        row.item.ir_right_level = 10'(irr);
        row.item.echo_width_us = 16'(echo);
        row.item.sample_valid = sv;
        row.item.left_edge = le;
        row.item.right_edge = re;
        row.item.ms_strobe = ms;
        row.fixed_on = fx_on;
        row.fixed = fx;
        return row;
    endfunction

    function automatic cfg_t directed_cfg(input int sel);
        cfg_t c;
        c = CFG_RESET;
        if (sel == DCFG_SHORT)
        begin
            // One-count limits so each busy phase ends within a couple of beats.
            c.back_time_ms = 16'd1;
            c.rotate_ticks = 8'd1;
            c.turn_ticks = 8'd1;
        end
        else
        begin
            // Zero limits, nonzero IR levels detected, widest near range, duty extremes.
            c.ir_detect_level = 10'd0;
            c.near_distance_cm = 8'd255;
            c.back_time_ms = 16'd0;
            c.rotate_ticks = 8'd0;
            c.turn_ticks = 8'd0;
            c.turn_speed = 8'd255;
            c.cruise_speed = 8'd0;
        end
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.ir_detect_level = 10'($urandom_range(0, 1023));
        c.near_distance_cm = 8'($urandom_range(0, 255));
        c.back_time_ms = 16'($urandom_range(0, 6));
        c.rotate_ticks = 8'($urandom_range(0, 8));
        c.turn_ticks = 8'($urandom_range(0, 8));
        c.turn_speed = 8'($urandom_range(0, 255));
        c.cruise_speed = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // IR level: rails, the detection edge, or anywhere.
    function automatic logic [9:0] pick_ir_level();
        int v;
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 1023;
            2:
            begin
                v = int'(pred_cfg.ir_detect_level) + int'($urandom_range(0, 2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
            end
            default: v = $urandom_range(0, 1023);
        endcase
        return v[9:0];
    endfunction

    // Random time slot. Samples are sparse and edges dense so busy phases run to their end.
    function automatic in_item_t make_slot(input bit dense_edges);
        in_item_t it;
        int       v;
        it.ir_left_level = pick_ir_level();
        it.ir_right_level = pick_ir_level();
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 65535;
            2:
            begin
                // Straddle the near boundary of the current setting.
                v = int'(pred_cfg.near_distance_cm) * 1000 / 17 + int'($urandom_range(0, 2)) - 1;
                if (v < 0)
                    v = 0;
            end
            3: v = $urandom_range(0, 65535);
            default: v = $urandom_range(0, 3000);
        endcase
        it.echo_width_us = v[15:0];
        it.sample_valid = ($urandom_range(0, 3) == 0);
        it.left_edge = dense_edges ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 3) != 0);
        it.right_edge = dense_edges ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 3) != 0);
        it.ms_strobe = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Write one register at the next edge; the caller drops cfg_we after the batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            R_IR_DETECT:     pred_cfg.ir_detect_level = data[9:0];
            R_NEAR_DISTANCE: pred_cfg.near_distance_cm = data[7:0];
            R_BACK_TIME:     pred_cfg.back_time_ms = data[15:0];
            R_ROTATE_TICKS:  pred_cfg.rotate_ticks = data[7:0];
            R_TURN_TICKS:    pred_cfg.turn_ticks = data[7:0];
            R_TURN_SPEED:    pred_cfg.turn_speed = data[7:0];
            R_CRUISE_SPEED:  pred_cfg.cruise_speed = data[7:0];
            default:
            begin
            end
        endcase
    endtask

    // Load a full setting. Upper data bits carry junk that the block must drop,
    // and the unused index gets a random write that must change nothing.
    task automatic load_config(input cfg_t c);
        write_reg(R_IR_DETECT, {6'($urandom), c.ir_detect_level});
        write_reg(R_NEAR_DISTANCE, {8'($urandom), c.near_distance_cm});
        write_reg(R_BACK_TIME, c.back_time_ms);
        write_reg(R_ROTATE_TICKS, {8'($urandom), c.rotate_ticks});
        write_reg(R_TURN_TICKS, {8'($urandom), c.turn_ticks});
        write_reg(R_TURN_SPEED, {8'($urandom), c.turn_speed});
        write_reg(R_CRUISE_SPEED, {8'($urandom), c.cruise_speed});
        write_reg(R_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Drop valid, wait for every predicted beat to come back, then let the pipe settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one slot and hold it until the block takes it. Stall is sampled on the
    // falling edge, where nothing moves, and the beat counts at the following rising edge.
    task automatic send_slot(input in_item_t it, input bit fixed_on, input result_t fixed);
        bit      taken;
        result_t predicted;
        in_valid <= 1'b1;
        ir_left_level <= it.ir_left_level;
        ir_right_level <= it.ir_right_level;
        echo_width_us <= it.echo_width_us;
        sample_valid <= it.sample_valid;
        left_edge <= it.left_edge;
        right_edge <= it.right_edge;
        ms_strobe <= it.ms_strobe;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        predicted = predict_drive(it);
        expected_drive_q.push_back(fixed_on ? fixed : predicted);
        beats_sent++;
        // Random gap on the sending side.
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // block fills up and pushes back on its input.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            stall_left = 39;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Check each result beat against the oldest prediction. Outputs are stable on the
    // falling edge, and a beat seen there is taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_drive_q.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, mode %0d", $time, drive_mode);
                error_count++;
            end
            else
            begin
                exp_drive = expected_drive_q.pop_front();
                check_field("motor_a_dir", 16'(exp_drive.motor_a_dir), 16'(motor_a_dir));
                check_field("motor_b_dir", 16'(exp_drive.motor_b_dir), 16'(motor_b_dir));
                check_field("motor_a_duty", 16'(exp_drive.motor_a_duty), 16'(motor_a_duty));
                check_field("motor_b_duty", 16'(exp_drive.motor_b_duty), 16'(motor_b_duty));
                check_field("drive_mode", 16'(exp_drive.drive_mode), 16'(drive_mode));
                check_field("obstacle_near", 16'(exp_drive.obstacle_near), 16'(obstacle_near));
                results_checked++;
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #500000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        cfg_t phase_cfg;
        int   phase_len;

        // Directed slots, reset settings first. Boundaries: a level equal to the
        // threshold is not a hit, an echo of 882 us is near at 15 cm, 883 us is not.
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 0, 0, 0, 1'b1,
                                       {D_STOP, D_STOP, 8'd0, 8'd0, M_STOP, 1'b0}));
        // Edges and strobe alongside an acted-on sample are not counted.
        directed_rows.push_back(mk_row(DCFG_NONE, 500, 500, 883, 1, 1, 1, 1, 1'b1,
                                       {D_FWD, D_FWD, 8'd170, 8'd170, M_CRUISE, 1'b0}));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 882, 1, 0, 0, 0, 1'b1,
                                       {D_REV, D_REV, 8'd150, 8'd150, M_REVERSE, 1'b1}));
        // Sample while reversing refreshes the near flag only.
        directed_rows.push_back(mk_row(DCFG_NONE, 1023, 1023, 65535, 1, 1, 1, 1, 1'b1,
                                       {D_REV, D_REV, 8'd150, 8'd150, M_REVERSE, 1'b0}));
        // Short limits: reversal ends at once, then a rotation, both side turns,
        // a both-sides hit, and a zero echo read as near.
        directed_rows.push_back(mk_row(DCFG_SHORT, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 501, 0, 1000, 1, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 1, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 1023, 65535, 1, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 0, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 1023, 1023, 65535, 1, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 0, 0, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 0, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 1, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 1, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 1, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 0, 0, 1'b0, '0));
        // Zero limits and duty extremes, with zero back time going straight to rotation.
        directed_rows.push_back(mk_row(DCFG_ZERO, 1, 0, 65535, 1, 0, 0, 0, 1'b1,
                                       {D_FWD, D_REV, 8'd255, 8'd255, M_RIGHT, 1'b0}));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 15000, 1, 0, 0, 0, 1'b1,
                                       {D_FWD, D_FWD, 8'd0, 8'd0, M_CRUISE, 1'b0}));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 14999, 1, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        directed_rows.push_back(mk_row(DCFG_NONE, 0, 0, 0, 0, 1, 0, 0, 1'b0, '0));

        // Hold reset at the start, then release it once for the whole run.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg_sel != DCFG_NONE)
            begin
                wait_idle();
                load_config(directed_cfg(directed_rows[i].cfg_sel));
            end
            send_slot(directed_rows[i].item, directed_rows[i].fixed_on, directed_rows[i].fixed);
        end

        // Random phases, each under its own setting: all maxima, all minima, the reset
        // values, unreachable limits so the counters saturate, then short random limits.
        // The long hold-off lands in phase 4, and the last phase runs with no idling.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    phase_cfg = '1;
                    phase_len = 60;
                end
                1:
                begin
                    phase_cfg = '0;
                    phase_len = 200;
                end
                2:
                begin
                    phase_cfg = CFG_RESET;
                    phase_len = 150;
                end
                3:
                begin
                    phase_cfg = random_cfg();
                    phase_cfg.rotate_ticks = 8'd255;
                    phase_cfg.turn_ticks = 8'd255;
                    phase_len = 400;
                end
                default:
                begin
                    phase_cfg = random_cfg();
                    phase_len = 210;
                end
            endcase
            load_config(phase_cfg);
            idle_on = (ph != NUM_PHASES - 1);
            if (ph == 4)
                hold_req = 1'b1;
            for (int n = 0; n < phase_len; n++)
                send_slot(make_slot(ph == 3), 1'b0, '0);
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d input beats and %0d checked drive results", beats_sent,
                 results_checked);
        $display("under %0d register settings, with stalls on both sides and one long hold-off",
                 settings_loaded);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/oads_pkg.sv
rtl/oads_cfg.sv
rtl/oads_core.sv
rtl/obstacle_avoid_drive_sequencer.sv
test/obstacle_avoid_drive_sequencer_tb.sv
